// ===== rtl/csp_pkg.sv =====
// shared types and constants for the column stripe pair detector
// payload structs, configuration struct, register map and reset values
// no dependencies
package csp_pkg;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last_pixel;
    } pixel_item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] first_position;
        logic [7:0] second_position;
    } result_item_t;

    typedef struct packed {
        logic [7:0] gradient_threshold;
        logic [7:0] run_width_min;
        logic [7:0] run_width_max;
        logic [7:0] gap_min;
        logic [7:0] gap_max;
    } cfg_t;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRADIENT_THRESHOLD = 3'd0,
        REG_RUN_WIDTH_MIN      = 3'd1,
        REG_RUN_WIDTH_MAX      = 3'd2,
        REG_GAP_MIN            = 3'd3,
        REG_GAP_MAX            = 3'd4
    } reg_index_t;

    localparam logic [7:0] THRESHOLD_RESET = 8'd30;
    localparam logic [7:0] RUN_MIN_RESET   = 8'd2;
    localparam logic [7:0] RUN_MAX_RESET   = 8'd6;
    localparam logic [7:0] GAP_MIN_RESET   = 8'd2;
    localparam logic [7:0] GAP_MAX_RESET   = 8'd15;

    localparam int RUN_W = 9;

endpackage

// ===== rtl/csp_regs.sv =====
// configuration register file behind the apb-style port
// depends on csp_pkg for the register map and reset values
module csp_regs
    import csp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_GRADIENT_THRESHOLD: cfg_next.gradient_threshold = pwdata[7:0];
                REG_RUN_WIDTH_MIN:      cfg_next.run_width_min      = pwdata[7:0];
                REG_RUN_WIDTH_MAX:      cfg_next.run_width_max      = pwdata[7:0];
                REG_GAP_MIN:            cfg_next.gap_min            = pwdata[7:0];
                REG_GAP_MAX:            cfg_next.gap_max            = pwdata[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GRADIENT_THRESHOLD: prdata = {24'd0, cfg_reg.gradient_threshold};
            REG_RUN_WIDTH_MIN:      prdata = {24'd0, cfg_reg.run_width_min};
            REG_RUN_WIDTH_MAX:      prdata = {24'd0, cfg_reg.run_width_max};
            REG_GAP_MIN:            prdata = {24'd0, cfg_reg.gap_min};
            REG_GAP_MAX:            prdata = {24'd0, cfg_reg.gap_max};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gradient_threshold <= THRESHOLD_RESET;
            cfg_reg.run_width_min      <= RUN_MIN_RESET;
            cfg_reg.run_width_max      <= RUN_MAX_RESET;
            cfg_reg.gap_min            <= GAP_MIN_RESET;
            cfg_reg.gap_max            <= GAP_MAX_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/csp_input_stage.sv =====
// input register for pixel transfers, with the advance decision
// depends on csp_pkg for the pixel item struct
module csp_input_stage
    import csp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pixel_item_t s_data,
    input  logic        out_busy,
    output logic        step,
    output pixel_item_t item
);

    logic        in_valid_reg;
    logic        in_valid_next;
    pixel_item_t in_data_reg;

    // only a closing pixel needs room in the result register
    assign step    = in_valid_reg && (!in_data_reg.last_pixel || !out_busy);
    assign s_ready = !in_valid_reg || step;
    assign item    = in_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

endmodule

// ===== rtl/csp_search.sv =====
// pixel history, gradient and stripe pair search machine for one column
// depends on csp_pkg for the item, result and configuration structs
module csp_search
    import csp_pkg::*;
#(
    parameter int MAX_PIXELS = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  pixel_item_t  item,
    input  cfg_t         cfg,
    output result_item_t result
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int IDX_W = $clog2(MAX_PIXELS);
    localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;
    localparam logic [RUN_W-1:0] RUN_SAT = {RUN_W{1'b1}};

    typedef enum logic [2:0] {
        S_WAIT_RISE = 3'd0,
        S_IN_RISE   = 3'd1,
        S_WAIT_FALL = 3'd2,
        S_IN_FALL   = 3'd3,
        S_MATCHED   = 3'd4
    } search_state_t;

    search_state_t    state_reg, state_next, state_scan;
    logic [7:0]       older_reg, older_next;
    logic [7:0]       newer_reg, newer_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [RUN_W-1:0] run_reg, run_next, run_scan, run_inc;
    logic [IDX_W-1:0] first_reg, first_next, first_scan;
    logic [IDX_W-1:0] second_reg, second_next, second_scan;

    logic              active;
    logic              have_grad;
    logic [IDX_W-1:0]  idx;
    logic signed [10:0] grad;
    logic signed [10:0] thr;
    logic              rise;
    logic              fall;
    logic              width_bad;
    logic [IDX_W-1:0]  gap;
    logic              gap_bad;

    assign active    = count_reg < CNT_W'(MAX_PIXELS);
    assign have_grad = active && (count_reg >= CNT_W'(2));
    assign idx       = IDX_W'(count_reg - CNT_W'(2));
    assign grad      = $signed({2'b00, older_reg, 1'b0}) - $signed({2'b00, item.pixel, 1'b0});
    assign thr       = $signed({3'b000, cfg.gradient_threshold});
    assign rise      = grad > thr;
    assign fall      = grad < -thr;
    assign run_inc   = (run_reg == RUN_SAT) ? run_reg : run_reg + RUN_W'(1);
    assign width_bad = (run_reg < {1'b0, cfg.run_width_min}) ||
                       (run_reg > {1'b0, cfg.run_width_max});
    assign gap       = idx - first_reg;
    assign gap_bad   = (CMP_W'(gap) < CMP_W'(cfg.gap_min)) ||
                       (CMP_W'(gap) > CMP_W'(cfg.gap_max));

    // one machine step for the gradient that this pixel completes
    always_comb begin
        state_scan  = state_reg;
        run_scan    = run_reg;
        first_scan  = first_reg;
        second_scan = second_reg;
        if (have_grad) begin
            case (state_reg)
                S_WAIT_RISE: begin
                    if (rise) begin
                        state_scan = S_IN_RISE;
                        run_scan   = run_inc;
                    end
                end
                S_IN_RISE: begin
                    if (rise) begin
                        run_scan = run_inc;
                    end else if (width_bad) begin
                        state_scan = S_WAIT_RISE;
                        run_scan   = '0;
                    end else begin
                        state_scan = S_WAIT_FALL;
                        first_scan = idx;
                        run_scan   = '0;
                    end
                end
                S_WAIT_FALL: begin
                    if (fall) begin
                        state_scan = S_IN_FALL;
                        run_scan   = run_inc;
                    end
                end
                S_IN_FALL: begin
                    if (fall) begin
                        run_scan = run_inc;
                    end else if (width_bad) begin
                        state_scan = S_WAIT_FALL;
                        run_scan   = '0;
                    end else if (gap_bad) begin
                        // rejected gap restarts the distance from here
                        state_scan = S_WAIT_FALL;
                        run_scan   = '0;
                        first_scan = idx;
                    end else begin
                        state_scan  = S_MATCHED;
                        second_scan = idx;
                    end
                end
                default: state_scan = state_reg;
            endcase
        end
    end

    always_comb begin
        state_next  = state_reg;
        run_next    = run_reg;
        first_next  = first_reg;
        second_next = second_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;
        count_next  = count_reg;
        if (step && active) begin
            state_next  = state_scan;
            run_next    = run_scan;
            first_next  = first_scan;
            second_next = second_scan;
            older_next  = newer_reg;
            newer_next  = item.pixel;
            count_next  = count_reg + CNT_W'(1);
        end
        if (step && item.last_pixel) begin
            state_next  = S_WAIT_RISE;
            run_next    = '0;
            first_next  = '0;
            second_next = '0;
            older_next  = '0;
            newer_next  = '0;
            count_next  = '0;
        end
    end

    // result of a closing pixel, taken after its own gradient step
    always_comb begin
        result.found           = active ? (state_scan == S_MATCHED) : (state_reg == S_MATCHED);
        result.first_position  = active ? 8'(first_scan) : 8'(first_reg);
        result.second_position = result.found ?
                                 (active ? 8'(second_scan) : 8'(second_reg)) : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_WAIT_RISE;
            run_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            older_reg  <= '0;
            newer_reg  <= '0;
            count_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            run_reg    <= run_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            older_reg  <= older_next;
            newer_reg  <= newer_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/column_stripe_pair_detector.sv =====
// Column stripe pair detector, top level.
// Pixels of one image column segment arrive on the s_ channel (valid/ready),
// one transfer per pixel, with last_pixel set on the final pixel. For each
// column the block searches the gradient 2*p[i] - 2*p[i+2] for a rising run
// above the threshold followed by a falling run below minus the threshold,
// checks both run widths and the gap between them, and stops at the first
// match. The closing pixel produces exactly one result transfer on the m_
// channel: found, first_position and second_position. Other pixels produce
// nothing.
// Throughput: one pixel per cycle, unless a closing pixel waits on a stalled
// result register; the search machine takes one step per pixel between the
// input register and the result register, which takes each column's result.
// When the receiver stalls, the result register holds its value; pixels that
// do not close a column keep flowing, and the next closing pixel waits in the
// input register, after which s_ready drops. Reset (aresetn, synchronous,
// active low) empties both registers, restores the configuration defaults
// and clears the column state. The user writes configuration over the
// apb-style port only while the block is idle; the block does not check it.
// depends on csp_pkg, csp_regs, csp_input_stage and csp_search
module column_stripe_pair_detector
    import csp_pkg::*;
#(
    parameter int MAX_PIXELS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_item_t           s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_item_t          m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t         cfg;
    logic         step;
    pixel_item_t  item;
    result_item_t result;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_item_t out_data_reg;
    logic         out_busy;
    logic         out_load;

    csp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csp_input_stage u_input (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_busy (out_busy),
        .step     (step),
        .item     (item)
    );

    csp_search #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_busy = out_valid_reg && !m_ready;
    assign out_load = step && item.last_pixel;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (out_load) begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== rtl/csp_checker.sv =====
// port-level checks for the column stripe pair detector
// depends on csp_pkg; bound to column_stripe_pair_detector below
module csp_checker
    import csp_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_ready,
    input logic         m_valid,
    input logic         m_ready,
    input result_item_t m_data
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset leaves no result pending
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // with the result register empty, a pixel can always be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // no second position without a match
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.second_position == 8'd0)
        else $error("second position set without a match");

endmodule

bind column_stripe_pair_detector csp_checker u_csp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
